>>> rtl/urpd_pkg.sv
package urpd_pkg;

  localparam int CNT_W = 17;
  localparam int TMO_W = 17;
  localparam int TRIG_W = 8;
  localparam int CM_CFG_W = 10;
  localparam int DIST_W = 11;
  localparam int DUTY_W = 8;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W = (CNT_W > TMO_W) ? CNT_W : TMO_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // reciprocal of 58 for the tick-to-centimeter conversion
  localparam int RECIP_SH = CNT_W + 6;
  localparam int RECIP_W = CNT_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'd58);
  localparam int PROD_W = CNT_W + RECIP_W;
  localparam logic [CNT_W-1:0] CM_DIV = CNT_W'(58);
  localparam logic [CNT_W-1:0] CM_BIAS = CNT_W'(29);
  localparam logic [CNT_W-1:0] DIST_SAT = CNT_W'(2047);

  // target divider: numerator (max-cm)*255 + span/2, quotient 8 bits
  localparam int NUM_W = CM_CFG_W + 8;
  localparam int DSOR_W = CM_CFG_W + 7;
  localparam int QBITS = 8;
  localparam logic [DUTY_W-1:0] DUTY_FULL = {DUTY_W{1'b1}};

  localparam logic [TRIG_W-1:0] TRIG_RST = TRIG_W'(24);
  localparam logic [TMO_W-1:0] TMO_RST = TMO_W'(80000);
  localparam logic [CM_CFG_W-1:0] MIN_RST = CM_CFG_W'(5);
  localparam logic [CM_CFG_W-1:0] MAX_RST = CM_CFG_W'(200);

  localparam logic [CFG_IDX_W-1:0] REG_TRIG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TMO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic req_type;
    logic echo_level;
  } in_word_t;

  typedef struct packed {
    logic              trigger_level;
    logic              measure_done;
    logic              timed_out;
    logic [DIST_W-1:0] distance_cm;
    logic [DUTY_W-1:0] duty_level;
  } out_word_t;

  typedef struct packed {
    logic step;
    logic cm_mul;
    logic cm_fix;
    logic tgt_init;
    logic div_step;
    logic smooth;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic tmo;
    logic in_range;
  } dp_sts_t;

endpackage

>>> rtl/urpd_in_if.sv
interface urpd_in_if;
  logic               valid;
  logic               ready;
  urpd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/urpd_out_if.sv
interface urpd_out_if;
  logic                valid;
  logic                ready;
  urpd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/urpd_ctrl.sv
module urpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  urpd_pkg::dp_sts_t  sts,
  output urpd_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CM_MUL = 3'd1;
  localparam logic [2:0] S_CM_FIX = 3'd2;
  localparam logic [2:0] S_TGT = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_SMOOTH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] div_cnt;
  logic       accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.step = 1'b1;
          if (!sts.done) begin
            cmd.load_out = 1'b1;
          end else if (sts.tmo) begin
            state_next = S_SMOOTH;
          end else begin
            state_next = S_CM_MUL;
          end
        end
      end
      S_CM_MUL: begin
        cmd.cm_mul = 1'b1;
        state_next = S_CM_FIX;
      end
      S_CM_FIX: begin
        cmd.cm_fix = 1'b1;
        state_next = S_TGT;
      end
      S_TGT: begin
        cmd.tgt_init = 1'b1;
        state_next = sts.in_range ? S_DIV : S_SMOOTH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == 3'(urpd_pkg::QBITS - 1)) begin
          state_next = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        cmd.load_out = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 3'd1;
      end else begin
        div_cnt <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/urpd_dpath.sv
module urpd_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [urpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [urpd_pkg::CFG_W-1:0]         cfg_data,
  input  urpd_pkg::in_word_t                 in_data,
  input  urpd_pkg::ctl_cmd_t                 cmd,
  output urpd_pkg::dp_sts_t                  sts,
  output urpd_pkg::out_word_t                out_data
);

  logic [urpd_pkg::TRIG_W-1:0]   trig_ticks;
  logic [urpd_pkg::TMO_W-1:0]    tmo_ticks;
  logic [urpd_pkg::CM_CFG_W-1:0] min_cm;
  logic [urpd_pkg::CM_CFG_W-1:0] max_cm;

  logic [1:0]                    phase;
  logic [1:0]                    phase_next;
  logic [urpd_pkg::CNT_W-1:0]    phase_ticks;
  logic [urpd_pkg::CNT_W-1:0]    phase_ticks_next;
  logic [urpd_pkg::CNT_W-1:0]    pulse_ticks;
  logic [urpd_pkg::CNT_W-1:0]    pulse_ticks_next;
  logic                          last_echo;
  logic [urpd_pkg::DIST_W-1:0]   last_distance;
  logic [urpd_pkg::DUTY_W-1:0]   duty;
  logic [urpd_pkg::DUTY_W-1:0]   duty_next;
  logic                          tmo_flag;

  logic [urpd_pkg::CNT_W-1:0]    pt_inc;
  logic [urpd_pkg::CNT_W-1:0]    pu_inc;
  logic                          step_done;
  logic                          step_tmo;

  logic [urpd_pkg::CNT_W-1:0]    num_cm;
  logic [urpd_pkg::PROD_W-1:0]   prod;
  logic [urpd_pkg::CNT_W-1:0]    q_est;
  logic [urpd_pkg::CNT_W-1:0]    q_rem;
  logic [urpd_pkg::CNT_W-1:0]    cm_fixed;

  logic                          near;
  logic                          far;
  logic [urpd_pkg::CM_CFG_W-1:0] span;
  logic [urpd_pkg::CM_CFG_W-1:0] val;
  logic [urpd_pkg::NUM_W-1:0]    num_div;
  logic [urpd_pkg::NUM_W-1:0]    rem;
  logic [urpd_pkg::DSOR_W-1:0]   dsor;
  logic                          q_bit;
  logic [urpd_pkg::DUTY_W-1:0]   target;

  logic [urpd_pkg::DUTY_W:0]     diff;
  logic [urpd_pkg::DUTY_W:0]     mag;
  logic [urpd_pkg::DUTY_W-1:0]   adj;

  assign pt_inc = (phase_ticks == urpd_pkg::CNT_MAX) ? phase_ticks
                                                     : phase_ticks + 1'b1;
  assign pu_inc = (pulse_ticks == urpd_pkg::CNT_MAX) ? pulse_ticks
                                                     : pulse_ticks + 1'b1;

  // per-item phase update
  always_comb begin
    phase_next = phase;
    phase_ticks_next = phase_ticks;
    pulse_ticks_next = pulse_ticks;
    step_done = 1'b0;
    step_tmo = 1'b0;
    if (in_data.req_type == urpd_pkg::REQ_START) begin
      phase_next = urpd_pkg::PH_TRIG;
      phase_ticks_next = '0;
      pulse_ticks_next = '0;
    end else begin
      case (phase)
        urpd_pkg::PH_TRIG: begin
          if (urpd_pkg::CMP_W'(pt_inc) >= urpd_pkg::CMP_W'(trig_ticks)) begin
            phase_next = urpd_pkg::PH_WAIT;
            phase_ticks_next = '0;
          end else begin
            phase_ticks_next = pt_inc;
          end
        end
        urpd_pkg::PH_WAIT, urpd_pkg::PH_MEAS: begin
          if (phase == urpd_pkg::PH_WAIT) begin
            if (in_data.echo_level && !last_echo) begin
              phase_next = urpd_pkg::PH_MEAS;
              pulse_ticks_next = '0;
            end
          end else begin
            pulse_ticks_next = pu_inc;
            if (!in_data.echo_level) begin
              step_done = 1'b1;
            end
          end
          if (!step_done) begin
            phase_ticks_next = pt_inc;
            if (urpd_pkg::CMP_W'(pt_inc) >= urpd_pkg::CMP_W'(tmo_ticks) ||
                pt_inc == urpd_pkg::CNT_MAX) begin
              step_done = 1'b1;
              step_tmo = 1'b1;
            end
          end
          if (step_done) begin
            phase_next = urpd_pkg::PH_IDLE;
            phase_ticks_next = '0;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // ticks to centimeters: reciprocal estimate, then one correction
  assign num_cm = {1'b0, pulse_ticks[urpd_pkg::CNT_W-1:1]} + urpd_pkg::CM_BIAS;
  assign prod = urpd_pkg::PROD_W'(num_cm) * urpd_pkg::PROD_W'(urpd_pkg::RECIP);
  assign q_rem = num_cm - urpd_pkg::CNT_W'(q_est * urpd_pkg::CM_DIV);
  always_comb begin
    cm_fixed = (q_rem >= urpd_pkg::CM_DIV) ? q_est + 1'b1 : q_est;
    if (cm_fixed > urpd_pkg::DIST_SAT) begin
      cm_fixed = urpd_pkg::DIST_SAT;
    end
  end

  // target mapping
  assign near = last_distance <= urpd_pkg::DIST_W'(min_cm);
  assign far = last_distance >= urpd_pkg::DIST_W'(max_cm);
  assign span = max_cm - min_cm;
  assign val = max_cm - last_distance[urpd_pkg::CM_CFG_W-1:0];
  assign num_div = (urpd_pkg::NUM_W'(val) << 8) - urpd_pkg::NUM_W'(val)
                 + urpd_pkg::NUM_W'(span >> 1);
  assign q_bit = rem >= urpd_pkg::NUM_W'(dsor);

  // move duty a quarter of the way, truncated toward zero
  assign diff = {1'b0, target} - {1'b0, duty};
  assign mag = diff[urpd_pkg::DUTY_W] ? -diff : diff;
  assign adj = {1'b0, mag[urpd_pkg::DUTY_W:2]};
  assign duty_next = diff[urpd_pkg::DUTY_W] ? duty - adj : duty + adj;

  assign sts.done = step_done;
  assign sts.tmo = step_tmo;
  assign sts.in_range = !near && !far;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_ticks <= urpd_pkg::TRIG_RST;
      tmo_ticks <= urpd_pkg::TMO_RST;
      min_cm <= urpd_pkg::MIN_RST;
      max_cm <= urpd_pkg::MAX_RST;
      phase <= urpd_pkg::PH_IDLE;
      phase_ticks <= '0;
      pulse_ticks <= '0;
      last_echo <= 1'b0;
      last_distance <= '0;
      duty <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          urpd_pkg::REG_TRIG: trig_ticks <= cfg_data[urpd_pkg::TRIG_W-1:0];
          urpd_pkg::REG_TMO:  tmo_ticks <= cfg_data[urpd_pkg::TMO_W-1:0];
          urpd_pkg::REG_MIN:  min_cm <= cfg_data[urpd_pkg::CM_CFG_W-1:0];
          urpd_pkg::REG_MAX:  max_cm <= cfg_data[urpd_pkg::CM_CFG_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        phase <= phase_next;
        phase_ticks <= phase_ticks_next;
        pulse_ticks <= pulse_ticks_next;
        last_echo <= in_data.echo_level;
        if (step_tmo) begin
          last_distance <= '0;
        end
      end
      if (cmd.cm_fix) begin
        last_distance <= cm_fixed[urpd_pkg::DIST_W-1:0];
      end
      if (cmd.smooth) begin
        duty <= duty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      tmo_flag <= step_tmo;
      target <= '0;
    end
    if (cmd.cm_mul) begin
      q_est <= urpd_pkg::CNT_W'(prod >> urpd_pkg::RECIP_SH);
    end
    if (cmd.tgt_init) begin
      target <= near ? urpd_pkg::DUTY_FULL : '0;
      rem <= num_div;
      dsor <= urpd_pkg::DSOR_W'(span) << (urpd_pkg::QBITS - 1);
    end
    if (cmd.div_step) begin
      if (q_bit) begin
        rem <= rem - urpd_pkg::NUM_W'(dsor);
      end
      dsor <= dsor >> 1;
      target <= {target[urpd_pkg::DUTY_W-2:0], q_bit};
    end
    if (cmd.load_out) begin
      if (cmd.smooth) begin
        out_data.trigger_level <= phase == urpd_pkg::PH_TRIG;
        out_data.measure_done <= 1'b1;
        out_data.timed_out <= tmo_flag;
        out_data.distance_cm <= last_distance;
        out_data.duty_level <= duty_next;
      end else begin
        out_data.trigger_level <= phase_next == urpd_pkg::PH_TRIG;
        out_data.measure_done <= 1'b0;
        out_data.timed_out <= 1'b0;
        out_data.distance_cm <= last_distance;
        out_data.duty_level <= duty;
      end
    end
  end

endmodule

>>> rtl/ultrasonic_range_to_pwm_duty_core.sv
// A tick that completes nothing gives its word in the cycle after acceptance.
// A timeout goes via smoothing; an echo out of range via multiply, fix, target and
// smoothing; one inside also via the 8-step restoring divider of the duty target.
// Throughput: one word per cycle while nothing completes and the output drains;
// a completion holds the input until its word is registered.
// Reset (rst, synchronous): registers to defaults, phase idle, counters and duty zero.
module ultrasonic_range_to_pwm_duty_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [urpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urpd_pkg::CFG_W-1:0]     cfg_data,
  urpd_in_if.sink                        din,
  urpd_out_if.source                     dout
);

  urpd_pkg::ctl_cmd_t cmd;
  urpd_pkg::dp_sts_t  sts;

  urpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  urpd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (din.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (dout.data)
  );

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    din.ready |-> (!dout.valid || dout.ready))
    else $error("input taken with no room for its word");

  a_quiet_tick: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && !sts.done) |=> (dout.valid && !dout.data.measure_done))
    else $error("tick word not registered");

  a_smooth_out: assert property (@(posedge clk) disable iff (rst)
    cmd.smooth |=> (dout.valid && dout.data.measure_done))
    else $error("completion word missing");

  a_done_trig: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.data.measure_done) |-> !dout.data.trigger_level)
    else $error("trigger high on a completion word");

endmodule

>>> verif/ultrasonic_range_to_pwm_duty_core_test.sv
module ultrasonic_range_to_pwm_duty_core_test;
  import urpd_pkg::*;

  typedef struct packed {
    logic                 cfg_row;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    in_word_t             w;
    logic                 pinned;
    out_word_t            want;
  } plan_row_t;

  typedef struct packed {
    logic      pinned;
    out_word_t want;
  } mark_t;

  localparam int RANDOM_WORDS = 1300;
  localparam longint STOP_AFTER = 64'd16_000_000;
  localparam logic [TMO_W-1:0] TMO_TOP = {TMO_W{1'b1}};

  localparam in_word_t TICK_LO = '{req_type: REQ_TICK, echo_level: 1'b0};
  localparam in_word_t TICK_HI = '{req_type: REQ_TICK, echo_level: 1'b1};
  localparam in_word_t START_LO = '{req_type: REQ_START, echo_level: 1'b0};
  localparam in_word_t START_HI = '{req_type: REQ_START, echo_level: 1'b1};

  localparam out_word_t QUIET = '0;
  localparam out_word_t TRIG_ON = '{trigger_level: 1'b1, default: '0};
  localparam out_word_t GAVE_UP = '{measure_done: 1'b1, timed_out: 1'b1, default: '0};
  localparam out_word_t CLOSE_HIT = '{measure_done: 1'b1, duty_level: 8'd63, default: '0};

  // idle ticks, restart while busy, zero trigger and zero timeout, echo already high,
  // completion winning over timeout, then the widest timeout and the full map range
  localparam plan_row_t PLAN [0:31] = '{
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b1, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_HI, 1'b1, QUIET},
    '{1'b0, REG_TRIG, '0, START_HI, 1'b1, TRIG_ON},
    '{1'b0, REG_TRIG, '0, START_LO, 1'b1, TRIG_ON},
    '{1'b1, REG_TRIG, 17'd0, TICK_LO, 1'b0, QUIET},
    '{1'b1, REG_TMO, 17'd0, TICK_LO, 1'b0, QUIET},
    '{1'b1, REG_MIN, 17'd1023, TICK_LO, 1'b0, QUIET},
    '{1'b1, REG_MAX, 17'd0, TICK_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b1, GAVE_UP},
    '{1'b1, REG_TMO, 17'd2, TICK_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, START_HI, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_HI, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_HI, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b1, GAVE_UP},
    '{1'b0, REG_TRIG, '0, START_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_HI, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b1, CLOSE_HIT},
    '{1'b1, REG_TRIG, 17'd1, TICK_LO, 1'b0, QUIET},
    '{1'b1, REG_TMO, 17'd131071, TICK_LO, 1'b0, QUIET},
    '{1'b1, REG_MIN, 17'd0, TICK_LO, 1'b0, QUIET},
    '{1'b1, REG_MAX, 17'd1023, TICK_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, START_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_HI, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_HI, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b0, QUIET},
    '{1'b1, REG_TMO, 17'd1, TICK_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, START_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b0, QUIET},
    '{1'b0, REG_TRIG, '0, TICK_LO, 1'b0, QUIET}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  urpd_in_if  din_ch ();
  urpd_out_if dout_ch ();

  ultrasonic_range_to_pwm_duty_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch),
    .dout      (dout_ch)
  );

  // ranging state and register copies
  logic [1:0]          stage;
  logic [CNT_W-1:0]    stage_ticks;
  logic [CNT_W-1:0]    echo_ticks;
  logic                echo_prev;
  logic [DIST_W-1:0]   range_cm;
  logic [DUTY_W-1:0]   duty;
  logic [TRIG_W-1:0]   trig_len;
  logic [TMO_W-1:0]    tmo_len;
  logic [CM_CFG_W-1:0] near_cm;
  logic [CM_CFG_W-1:0] far_cm;

  out_word_t due_words [$];
  mark_t     row_marks [$];
  out_word_t want;
  out_word_t guess;
  mark_t     mark;

  int  words_in = 0;
  int  words_out = 0;
  int  errors = 0;
  int  readings = 0;
  int  timeouts = 0;
  int  settings = 0;
  int  budget = 0;
  bit  no_gaps = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #(STOP_AFTER);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic out_word_t echo_step(in_word_t w);
    logic      done;
    logic      gave_up;
    int        cm;
    int        goal;
    int        span;
    out_word_t r;
    done = 1'b0;
    gave_up = 1'b0;
    if (w.req_type == REQ_START) begin
      stage = PH_TRIG;
      stage_ticks = '0;
      echo_ticks = '0;
    end else if (stage == PH_TRIG) begin
      stage_ticks = sat_bump(stage_ticks);
      if (stage_ticks >= trig_len) begin
        stage = PH_WAIT;
        stage_ticks = '0;
      end
    end else if (stage != PH_IDLE) begin
      if (stage == PH_WAIT) begin
        if (w.echo_level && !echo_prev) begin
          stage = PH_MEAS;
          echo_ticks = '0;
        end
      end else begin
        echo_ticks = sat_bump(echo_ticks);
        done = !w.echo_level;
      end
      // a falling edge on this tick beats the timeout
      if (!done) begin
        stage_ticks = sat_bump(stage_ticks);
        if (stage_ticks >= tmo_len || stage_ticks == CNT_MAX) begin
          done = 1'b1;
          gave_up = 1'b1;
        end
      end
      if (done) begin
        if (gave_up) begin
          range_cm = '0;
          goal = 0;
        end else begin
          cm = ((int'(echo_ticks) >> 1) + 29) / 58;
          if (cm > 2047) cm = 2047;
          range_cm = DIST_W'(cm);
          span = int'(far_cm) - int'(near_cm);
          if (cm <= int'(near_cm)) goal = 255;
          else if (cm >= int'(far_cm)) goal = 0;
          else goal = ((int'(far_cm) - cm) * 255 + span / 2) / span;
        end
        // signed divide truncates toward zero
        duty = DUTY_W'(int'(duty) + (goal - int'(duty)) / 4);
        stage = PH_IDLE;
        stage_ticks = '0;
      end
    end
    echo_prev = w.echo_level;
    r.trigger_level = (stage == PH_TRIG);
    r.measure_done = done;
    r.timed_out = gave_up;
    r.distance_cm = range_cm;
    r.duty_level = duty;
    return r;
  endfunction

  function automatic void note_field(string field, logic [DIST_W-1:0] want_v,
                                     logic [DIST_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1) begin
        words_out++;
        if (due_words.size() == 0) begin
          $display("%0t: result word %h arrived, expected none", $time, dout_ch.data);
          errors++;
        end else begin
          want = due_words.pop_front();
          note_field("trigger_level", DIST_W'(want.trigger_level),
                     DIST_W'(dout_ch.data.trigger_level));
          note_field("measure_done", DIST_W'(want.measure_done),
                     DIST_W'(dout_ch.data.measure_done));
          note_field("timed_out", DIST_W'(want.timed_out),
                     DIST_W'(dout_ch.data.timed_out));
          note_field("distance_cm", want.distance_cm, dout_ch.data.distance_cm);
          note_field("duty_level", DIST_W'(want.duty_level),
                     DIST_W'(dout_ch.data.duty_level));
        end
      end
      if (din_ch.valid === 1'b1 && din_ch.ready === 1'b1) begin
        guess = echo_step(din_ch.data);
        readings += int'(guess.measure_done);
        timeouts += int'(guess.timed_out);
        mark = row_marks.pop_front();
        due_words.push_back(mark.pinned ? mark.want : guess);
      end
    end
  end

  // result side: stall a random number of cycles before each word, unless no_gaps is set
  initial begin
    int stall;
    dout_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        dout_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_ch.ready <= 1'b1;
      do @(posedge clk); while (dout_ch.valid !== 1'b1);
    end
  end

  // valid stays high on return; the next call either replaces the word or drops valid
  task automatic push_word(in_word_t w, logic pinned, out_word_t pin_want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    row_marks.push_back('{pinned: pinned, want: pin_want});
    if (gap != 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid <= 1'b1;
    din_ch.data <= w;
    do @(posedge clk); while (din_ch.ready !== 1'b1);
    words_in++;
  endtask

  task automatic feed(logic req, logic echo);
    in_word_t w;
    w.req_type = req;
    w.echo_level = echo;
    if (budget > 0) begin
      budget--;
      push_word(w, 1'b0, QUIET);
    end
  endtask

  task automatic settle_block();
    din_ch.valid <= 1'b0;
    while (words_out != words_in) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_TRIG: trig_len = value[TRIG_W-1:0];
      REG_TMO:  tmo_len = value[TMO_W-1:0];
      REG_MIN:  near_cm = value[CM_CFG_W-1:0];
      REG_MAX:  far_cm = value[CM_CFG_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [TRIG_W-1:0] t, logic [TMO_W-1:0] m,
                              logic [CM_CFG_W-1:0] lo, logic [CM_CFG_W-1:0] hi);
    settle_block();
    write_reg(REG_TRIG, CFG_W'(t));
    write_reg(REG_TMO, CFG_W'(m));
    write_reg(REG_MIN, CFG_W'(lo));
    write_reg(REG_MAX, CFG_W'(hi));
    settings++;
  endtask

  // start, trigger, optional echo left high, wait, one echo pulse, a few trailing ticks
  task automatic run_reading();
    int   hold;
    int   pulse;
    logic hot;
    hot = ($urandom_range(0, 3) == 0);
    hold = (trig_len == 0) ? 1 : int'(trig_len);
    pulse = ($urandom_range(0, 3) == 0) ? $urandom_range(58, 400) : $urandom_range(0, 60);
    feed(REQ_START, 1'($urandom_range(0, 1)));
    repeat (hold) feed(REQ_TICK, hot);
    if (hot) repeat ($urandom_range(1, 3)) feed(REQ_TICK, 1'b1);
    repeat ($urandom_range(hot ? 1 : 0, 5)) feed(REQ_TICK, 1'b0);
    feed(REQ_TICK, 1'b1);
    repeat (pulse) feed(REQ_TICK, 1'b1);
    feed(REQ_TICK, 1'b0);
    repeat ($urandom_range(0, 3)) feed(REQ_TICK, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int                  base;
    int                  pick;
    logic [TRIG_W-1:0]   t;
    logic [TMO_W-1:0]    m;
    logic [CM_CFG_W-1:0] lo;
    logic [CM_CFG_W-1:0] hi;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    din_ch.valid <= 1'b0;
    din_ch.data <= '0;
    stage = PH_IDLE;
    stage_ticks = '0;
    echo_ticks = '0;
    echo_prev = 1'b0;
    range_cm = '0;
    duty = '0;
    trig_len = TRIG_RST;
    tmo_len = TMO_RST;
    near_cm = MIN_RST;
    far_cm = MAX_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].cfg_row) begin
        settle_block();
        write_reg(PLAN[i].idx, PLAN[i].value);
      end else begin
        push_word(PLAN[i].w, PLAN[i].pinned, PLAN[i].want);
      end
    end

    base = words_in;
    while (words_in - base < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) t = '0;
      else if (pick == 1) t = 8'd255;
      else t = TRIG_W'($urandom_range(1, 6));
      pick = $urandom_range(0, 7);
      case (pick)
        0:       m = '0;
        1, 2:    m = TMO_W'($urandom_range(1, 10));
        3:       m = TMO_W'($urandom_range(20, 250));
        4:       m = TMO_TOP;
        default: m = TMO_W'($urandom_range(300, 3000));
      endcase
      // short pulses give only a few centimeters, so keep the map window there
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        lo = CM_CFG_W'($urandom_range(0, 1023));
        hi = CM_CFG_W'($urandom_range(0, 1023));
      end else if (pick == 1) begin
        lo = CM_CFG_W'($urandom_range(0, 4));
        hi = lo;
      end else begin
        lo = CM_CFG_W'($urandom_range(0, 2));
        hi = CM_CFG_W'($urandom_range(int'(lo) + 1, 6));
      end
      program_regs(t, m, lo, hi);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        // stop feeding once the random word count is reached
        budget = RANDOM_WORDS - (words_in - base);
        case ($urandom_range(0, 7))
          0: repeat ($urandom_range(3, 20))
               feed(1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)));
          1: begin
            if (budget > 40) budget = $urandom_range(1, 40);
            run_reading();
          end
          default: run_reading();
        endcase
      end
    end
    no_gaps = 1'b0;

    settle_block();
    repeat (24) @(posedge clk);
    if (due_words.size() != 0)
      $display("%0t: %0d result words never arrived", $time, due_words.size());
    $display("Sent %0d words; %0d readings finished, %0d of them by timeout.",
             words_in, readings, timeouts);
    $display("Applied %0d register sets, from zero trigger and timeout to the widest counts.",
             settings);
    if (errors == 0 && due_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
